@@ hw/rtl/timestamp_to_calendar_date_core_macros.svh @@
// Assertion macros used by the checker file of the timestamp converter.
`ifndef TIMESTAMP_TO_CALENDAR_DATE_CORE_MACROS_SVH
`define TIMESTAMP_TO_CALENDAR_DATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define T2C_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("timestamp converter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define T2C_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("timestamp converter check failed");

`endif

@@ hw/rtl/ts2cal_pkg.sv @@
// Shared types, constants and the month length table of the timestamp converter.
package ts2cal_pkg;

  localparam logic [31:0] LimitTs       = 32'd4102444800;
  localparam logic [11:0] EpochYear     = 12'd1970;
  localparam logic [15:0] SecsPerMin    = 16'd60;
  localparam logic [15:0] HoursPerCycle = 16'd35064;
  localparam logic [15:0] HoursPerDay   = 16'd24;
  localparam logic [13:0] HoursPerYear  = 14'd8760;
  localparam logic [8:0]  LeapDayOfYear = 9'd60;
  localparam int unsigned MonthsPerYear = 12;

  // Two quotient bits per divider step; the dividend width is twice the step count.
  localparam int unsigned SecDivSteps = 16;
  localparam int unsigned MinDivSteps = 14;
  localparam int unsigned CycDivSteps = 11;
  localparam int unsigned HrDivSteps  = 7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_STEP,
    OP_SEC_END,
    OP_MIN_END,
    OP_CYC_END,
    OP_YEAR_STEP,
    OP_HR_END,
    OP_MON_ADJ,
    OP_MON_STEP,
    OP_PUBLISH
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_BY_MIN,
    DIV_BY_CYCLE,
    DIV_BY_DAY
  } div_sel_e;

  typedef struct packed {
    dp_op_e   op;
    div_sel_e div;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic leap_day;
    logic month_done;
  } sts_t;

  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] len;
    unique case (idx)
      4'd1:                         len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:      len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/ts2cal_ctrl.sv @@
// Sequencer of the timestamp converter: steps the datapath and owns the handshakes.
module ts2cal_ctrl
  import ts2cal_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_SEC,
    S_END_SEC,
    S_DIV_MIN,
    S_END_MIN,
    S_DIV_CYC,
    S_END_CYC,
    S_YEAR,
    S_DIV_HR,
    S_END_HR,
    S_MON_ADJ,
    S_MON_STEP,
    S_FINISH
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q;
  logic       out_valid_q;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op  = OP_NONE;
    cmd_o.div = DIV_BY_MIN;
    unique case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_DIV_SEC:  cmd_o.op = OP_DIV_STEP;
      S_END_SEC:  cmd_o.op = OP_SEC_END;
      S_DIV_MIN:  cmd_o.op = OP_DIV_STEP;
      S_END_MIN:  cmd_o.op = OP_MIN_END;
      S_DIV_CYC: begin
        cmd_o.op  = OP_DIV_STEP;
        cmd_o.div = DIV_BY_CYCLE;
      end
      S_END_CYC:  cmd_o.op = OP_CYC_END;
      S_YEAR:     cmd_o.op = OP_YEAR_STEP;
      S_DIV_HR: begin
        cmd_o.op  = OP_DIV_STEP;
        cmd_o.div = DIV_BY_DAY;
      end
      S_END_HR:   cmd_o.op = OP_HR_END;
      S_MON_ADJ:  cmd_o.op = OP_MON_ADJ;
      S_MON_STEP: cmd_o.op = OP_MON_STEP;
      S_FINISH:   cmd_o.op = slot_free ? OP_PUBLISH : OP_NONE;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_FINISH && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DIV_SEC;
            cnt_q   <= 4'(SecDivSteps - 1);
          end
        end
        S_DIV_SEC: begin
          if (cnt_q == '0) state_q <= S_END_SEC;
          else cnt_q <= cnt_q - 4'd1;
        end
        S_END_SEC: begin
          state_q <= S_DIV_MIN;
          cnt_q   <= 4'(MinDivSteps - 1);
        end
        S_DIV_MIN: begin
          if (cnt_q == '0) state_q <= S_END_MIN;
          else cnt_q <= cnt_q - 4'd1;
        end
        S_END_MIN: begin
          state_q <= S_DIV_CYC;
          cnt_q   <= 4'(CycDivSteps - 1);
        end
        S_DIV_CYC: begin
          if (cnt_q == '0) state_q <= S_END_CYC;
          else cnt_q <= cnt_q - 4'd1;
        end
        S_END_CYC: state_q <= S_YEAR;
        S_YEAR: begin
          if (sts_i.year_done) begin
            state_q <= S_DIV_HR;
            cnt_q   <= 4'(HrDivSteps - 1);
          end
        end
        S_DIV_HR: begin
          if (cnt_q == '0) state_q <= S_END_HR;
          else cnt_q <= cnt_q - 4'd1;
        end
        S_END_HR: state_q <= S_MON_ADJ;
        S_MON_ADJ: begin
          state_q <= sts_i.leap_day ? S_FINISH : S_MON_STEP;
        end
        S_MON_STEP: begin
          if (sts_i.month_done) state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/ts2cal_dp.sv @@
// Datapath of the timestamp converter: radix-4 constant divider, year and month walk, result register.
module ts2cal_dp
  import ts2cal_pkg::*;
(
  input  logic        clk_i,
  input  cmd_t        cmd_i,
  input  logic [31:0] timestamp_i,
  output sts_t        sts_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic        out_of_range_o
);

  // Dividend shifts out at the top while quotient bits shift in at the bottom.
  logic [31:0] num_q;
  logic [15:0] rem_q;
  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [11:0] yr_q;
  logic [15:0] hcy_q;
  logic [4:0]  hr_q;
  logic [8:0]  doy_q;
  logic [3:0]  mo_q;
  logic        oor_q;

  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic        out_of_range_q;

  logic [15:0] dvs;
  logic [16:0] part1;
  logic [16:0] part2;
  logic [15:0] rem1;
  logic [15:0] rem2;
  logic        qbit1;
  logic        qbit2;
  logic        leap;
  logic [13:0] year_hours;
  logic [4:0]  cur_len;

  always_comb begin
    unique case (cmd_i.div)
      DIV_BY_MIN:   dvs = SecsPerMin;
      DIV_BY_CYCLE: dvs = HoursPerCycle;
      DIV_BY_DAY:   dvs = HoursPerDay;
      default:      dvs = SecsPerMin;
    endcase
  end

  // Two restoring steps per cycle.
  always_comb begin
    part1 = {rem_q, num_q[31]};
    qbit1 = (part1 >= {1'b0, dvs});
    rem1  = qbit1 ? 16'(part1 - {1'b0, dvs}) : part1[15:0];
    part2 = {rem1, num_q[30]};
    qbit2 = (part2 >= {1'b0, dvs});
    rem2  = qbit2 ? 16'(part2 - {1'b0, dvs}) : part2[15:0];
  end

  assign leap       = (yr_q[1:0] == 2'b00);
  assign year_hours = leap ? (HoursPerYear + 14'(HoursPerDay)) : HoursPerYear;
  assign cur_len    = month_len(mo_q);

  assign sts_o.year_done  = (hcy_q < {2'b00, year_hours});
  assign sts_o.leap_day   = leap && (doy_q == LeapDayOfYear);
  assign sts_o.month_done = (mo_q >= 4'(MonthsPerYear - 1)) || ({4'b0, cur_len} >= doy_q);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        num_q <= timestamp_i;
        rem_q <= '0;
        oor_q <= (timestamp_i >= LimitTs);
      end
      OP_DIV_STEP: begin
        num_q <= {num_q[29:0], qbit1, qbit2};
        rem_q <= rem2;
      end
      OP_SEC_END: begin
        sec_q <= rem_q[5:0];
        num_q <= {num_q[2*MinDivSteps-1:0], {(32 - 2*MinDivSteps){1'b0}}};
        rem_q <= '0;
      end
      OP_MIN_END: begin
        min_q <= rem_q[5:0];
        num_q <= {num_q[2*CycDivSteps-1:0], {(32 - 2*CycDivSteps){1'b0}}};
        rem_q <= '0;
      end
      OP_CYC_END: begin
        yr_q  <= EpochYear + {4'b0, num_q[5:0], 2'b00};
        hcy_q <= rem_q;
      end
      OP_YEAR_STEP: begin
        if (sts_o.year_done) begin
          num_q <= {hcy_q[2*HrDivSteps-1:0], {(32 - 2*HrDivSteps){1'b0}}};
          rem_q <= '0;
        end else begin
          yr_q  <= yr_q + 12'd1;
          hcy_q <= hcy_q - {2'b00, year_hours};
        end
      end
      OP_HR_END: begin
        hr_q  <= rem_q[4:0];
        doy_q <= num_q[8:0] + 9'd1;
        mo_q  <= '0;
      end
      OP_MON_ADJ: begin
        if (sts_o.leap_day) begin
          mo_q  <= 4'd1;
          doy_q <= 9'd29;
        end else if (leap && (doy_q > LeapDayOfYear)) begin
          doy_q <= doy_q - 9'd1;
        end
      end
      OP_MON_STEP: begin
        if (!sts_o.month_done) begin
          doy_q <= doy_q - {4'b0, cur_len};
          mo_q  <= mo_q + 4'd1;
        end
      end
      OP_PUBLISH: begin
        out_of_range_q <= oor_q;
        year_q         <= oor_q ? '0 : yr_q;
        month_q        <= oor_q ? '0 : mo_q + 4'd1;
        day_q          <= oor_q ? '0 : doy_q[4:0];
        hour_q         <= oor_q ? '0 : hr_q;
        minute_q       <= oor_q ? '0 : min_q;
        second_q       <= oor_q ? '0 : sec_q;
      end
      default: begin
      end
    endcase
  end

  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_o          = day_q;
  assign hour_o         = hour_q;
  assign minute_o       = minute_q;
  assign second_o       = second_q;
  assign out_of_range_o = out_of_range_q;

endmodule

@@ hw/rtl/timestamp_to_calendar_date_core.sv @@
// Top level of the seconds-since-epoch to UTC calendar date converter.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_ready_o | timestamp_i[31:0]
//   out     | output    | out_valid_o/out_ready_i | year, month, day, hour, minute, second,
//           |           |                         | out_of_range
//
// One item at a time; an item passes through the shared radix-4 divider (16 + 14 + 11 + 7
// steps for the /60, /60, /35064 and /24 passes), one to four year steps and up to twelve
// month steps, and the sequencer returns to idle before it takes the next item.
// The result sits in an output register; the next item is accepted while it waits.
// A finished item stalls in the last state only while the previous result is untaken.
// Reset clears the sequencer and the output valid; payload registers are not reset.
module timestamp_to_calendar_date_core
  import ts2cal_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic        out_of_range_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: walks divide, year, month and publish phases.
  ts2cal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: holds the working values and the result register.
  ts2cal_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .timestamp_i    (timestamp_i),
    .sts_o          (sts),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_o          (day_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

@@ hw/rtl/ts2cal_sva.sv @@
// Port-level checker of the timestamp converter and its bind to the top level.
`include "timestamp_to_calendar_date_core_macros.svh"

module ts2cal_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] timestamp_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] year_o,
  input logic [3:0]  month_o,
  input logic [4:0]  day_o,
  input logic [4:0]  hour_o,
  input logic [5:0]  minute_o,
  input logic [5:0]  second_o,
  input logic        out_of_range_o
);

  logic        in_fire;
  logic        out_stall;
  logic [38:0] out_payload;
  logic        zero_fields;
  logic        fields_legal;

  assign in_fire      = in_valid_i && in_ready_o;
  assign out_stall    = out_valid_o && !out_ready_i;
  assign out_payload  = {year_o, month_o, day_o, hour_o, minute_o, second_o, out_of_range_o};
  assign zero_fields  = (year_o == '0) && (month_o == '0) && (day_o == '0) &&
                        (hour_o == '0) && (minute_o == '0) && (second_o == '0);
  assign fields_legal = (year_o >= 12'd1970) && (year_o <= 12'd2099) &&
                        (month_o >= 4'd1) && (month_o <= 4'd12) &&
                        (day_o >= 5'd1) && (day_o <= 5'd31) && (hour_o <= 5'd23) &&
                        (minute_o <= 6'd59) && (second_o <= 6'd59);

  `T2C_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_payload))
  `T2C_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready_o)
  `T2C_ASSERT_IMPL(a_oor_zero, clk_i, rst_ni, out_valid_o && out_of_range_o, zero_fields)
  `T2C_ASSERT_IMPL(a_fields_legal, clk_i, rst_ni, out_valid_o && !out_of_range_o, fields_legal)

  logic unused_ts;
  assign unused_ts = ^timestamp_i;

endmodule

bind timestamp_to_calendar_date_core ts2cal_sva u_sva (.*);

@@ tb/sv/tb_timestamp_to_calendar_date_core.sv @@
// Self-checking testbench of the timestamp to calendar date converter.
module tb_timestamp_to_calendar_date_core;

  // Calendar arithmetic, kept apart from the design's own constants.
  localparam int unsigned SEC_PER_DAY    = 86400;
  localparam int unsigned HR_PER_DAY     = 24;
  localparam int unsigned HR_PER_CYCLE   = 1461 * 24;
  localparam int unsigned HR_PER_YEAR    = 8760;
  localparam int unsigned FIRST_YEAR     = 1970;
  localparam int unsigned LEAP_DOY       = 60;
  localparam int unsigned FIRST_LEAP_TS  = 63072000;   // 1972-01-01 00:00:00
  localparam int unsigned CYCLE_SECS     = 126230400;  // 1461 days
  localparam int unsigned LAST_VALID_TS  = 32'd4102444799;
  localparam int unsigned LAST_DAY_INDEX = 47481;      // 2099-12-31
  localparam int unsigned RANDOM_ITEMS   = 2000;
  // Longest quiet stretch of a correct run: a send gap, the conversion and a
  // receiver stall stacked together, taken many times over.
  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned SETTLE_CYCLES  = 120;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
    logic        past_range;
  } cal_date_t;

  typedef struct {
    logic [31:0] ts;
    bit          drain_first;
  } ts_item_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKY
  } rx_mode_e;

  logic        clk_i          = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [31:0] timestamp      = '0;
  logic        out_ready      = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  sec;
  logic        past_range;

  ts_item_t    ts_backlog[$];
  cal_date_t   expected_dates[$];

  int unsigned mismatches    = 0;
  int unsigned dates_checked = 0;
  int unsigned dates_past    = 0;
  int unsigned leap_days     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned burst_left    = 1;
  int unsigned gap_left      = 0;
  int unsigned rx_cycle      = 0;
  rx_mode_e    rx_mode       = RX_FREE;

  timestamp_to_calendar_date_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .timestamp_i   (timestamp),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .year_o        (year),
    .month_o       (month),
    .day_o         (day),
    .hour_o        (hour),
    .minute_o      (minute),
    .second_o      (sec),
    .out_of_range_o(past_range)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned days_in_month(input int unsigned m0);
    case (m0)
      1:           return 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  // Convert seconds since the epoch to a UTC date; every fourth year is leap,
  // which holds up to 2099, the last year the block accepts.
  function automatic cal_date_t calendar_of(input logic [31:0] ts);
    cal_date_t   d;
    int unsigned t;
    int unsigned yr;
    int unsigned yh;
    int unsigned doy;
    int unsigned mo;
    bit          found;
    d = '0;
    if (ts > LAST_VALID_TS) begin
      d.past_range = 1'b1;
      return d;
    end
    d.sec    = 6'(ts % 60);
    t        = ts / 60;
    d.minute = 6'(t % 60);
    t        = t / 60;
    yr       = FIRST_YEAR + 4 * (t / HR_PER_CYCLE);
    t        = t % HR_PER_CYCLE;
    found    = 1'b0;
    // Step over at most three single years inside the four-year cycle.
    for (int k = 0; k < 4; k++) begin
      if (!found) begin
        yh = HR_PER_YEAR + ((yr % 4 == 0) ? HR_PER_DAY : 0);
        if (t < yh) begin
          found = 1'b1;
        end else begin
          yr++;
          t -= yh;
        end
      end
    end
    d.hour = 5'(t % HR_PER_DAY);
    doy    = t / HR_PER_DAY + 1;
    mo     = 0;
    if (yr % 4 == 0 && doy == LEAP_DOY) begin
      d.month = 4'd2;
      d.day   = 5'd29;
    end else begin
      if (yr % 4 == 0 && doy > LEAP_DOY) doy--;
      while (mo < 11 && days_in_month(mo) < doy) begin
        doy -= days_in_month(mo);
        mo++;
      end
      d.month = 4'(mo + 1);
      d.day   = 5'(doy);
    end
    d.year = 12'(yr);
    return d;
  endfunction

  // Pick a timestamp that favors day, month and leap-year edges.
  function automatic logic [31:0] random_timestamp();
    int unsigned pick;
    int unsigned offs;
    pick = $urandom_range(99, 0);
    if (pick < 40) begin
      return $urandom_range(LAST_VALID_TS, 0);
    end else if (pick < 70) begin
      offs = $urandom_range(1, 0) ? $urandom_range(59, 0)
                                  : SEC_PER_DAY - 1 - $urandom_range(59, 0);
      return $urandom_range(LAST_DAY_INDEX, 0) * SEC_PER_DAY + offs;
    end else if (pick < 85) begin
      // Late February to early March of some leap year.
      return FIRST_LEAP_TS + $urandom_range(31, 0) * CYCLE_SECS
             + $urandom_range(61, 57) * SEC_PER_DAY + $urandom_range(SEC_PER_DAY - 1, 0);
    end else if (pick < 93) begin
      return $urandom;
    end else begin
      return $urandom_range(32'hFFFF_FFFF, LAST_VALID_TS + 1);
    end
  endfunction

  task automatic queue_ts(input logic [31:0] ts, input bit drain_first);
    ts_item_t it;
    it.ts          = ts;
    it.drain_first = drain_first;
    ts_backlog.push_back(it);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: send items in bursts with random gaps; an item flagged to drain
  // waits until every outstanding date has come back.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) expected_dates.push_back(calendar_of(timestamp));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (ts_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else if (ts_backlog[0].drain_first && expected_dates.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          timestamp <= ts_backlog[0].ts;
          in_valid  <= 1'b1;
          void'(ts_backlog.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(12, 1);
            // A quarter of the bursts run straight on; the rest idle long
            // enough to land anywhere in the conversion.
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(160, 1);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: switch between stall patterns, picking a new one at random now and then.
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = rx_mode_e'($urandom_range(3, 0));
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(1, 0));
      RX_SPARSE: out_ready <= ($urandom_range(7, 0) == 0);
      default:   out_ready <= ((rx_cycle / 32) % 2 == 0);
    endcase
  end

  // Monitor: compare each taken date with the oldest prediction.
  always @(posedge clk_i) begin
    cal_date_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        $error("unexpected date result: year %0d month %0d day %0d", year, month, day);
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        check_field("year", 32'(want.year), 32'(year));
        check_field("month", 32'(want.month), 32'(month));
        check_field("day", 32'(want.day), 32'(day));
        check_field("hour", 32'(want.hour), 32'(hour));
        check_field("minute", 32'(want.minute), 32'(minute));
        check_field("second", 32'(want.sec), 32'(sec));
        check_field("out_of_range", 32'(want.past_range), 32'(past_range));
        dates_checked++;
        if (want.past_range) dates_past++;
        if (want.month == 4'd2 && want.day == 5'd29) leap_days++;
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    // Field extremes and the minute, hour and day carries.
    queue_ts(32'd0, 1'b0);
    queue_ts(32'd59, 1'b0);
    queue_ts(32'd60, 1'b0);
    queue_ts(32'd3599, 1'b0);
    queue_ts(32'd86399, 1'b0);
    queue_ts(32'd86400, 1'b0);
    // Day 60 of a common year is March 1.
    queue_ts(32'd36633600, 1'b0);
    // Around the leap day of 1972 and its year end.
    queue_ts(32'd68169599, 1'b0);
    queue_ts(32'd68169600, 1'b0);
    queue_ts(32'd68255999, 1'b0);
    queue_ts(32'd68256000, 1'b1);
    queue_ts(32'd94694399, 1'b0);
    queue_ts(32'd94694400, 1'b0);
    // Four-year cycle edge, 2000 and 2096 leap days.
    queue_ts(32'd126230399, 1'b0);
    queue_ts(32'd126230400, 1'b0);
    queue_ts(32'd951782400, 1'b0);
    queue_ts(32'd3981312000, 1'b0);
    // Bit patterns and the sign-bit edge.
    queue_ts(32'h5555_5555, 1'b0);
    queue_ts(32'hAAAA_AAAA, 1'b0);
    queue_ts(32'h7FFF_FFFF, 1'b0);
    queue_ts(32'h8000_0000, 1'b0);
    // Last second of 2099 and everything past it.
    queue_ts(LAST_VALID_TS, 1'b0);
    queue_ts(LAST_VALID_TS + 1, 1'b1);
    queue_ts(32'hFFFF_FFFF, 1'b0);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      queue_ts(random_timestamp(), (n == RANDOM_ITEMS / 2) || ($urandom_range(199, 0) == 0));
    end

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;

    // Wait for the backlog to drain and every date to return, then settle.
    while (ts_backlog.size() != 0 || in_valid || expected_dates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d converted dates: %0d past 2099, %0d on February 29.",
             dates_checked, dates_past, leap_days);
    $display("Sender ran in random bursts with drain pauses; receiver cycled four stall modes.");
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
